@@ hw/rtl/go_to_goal_steering_assert.svh @@
// ----------------------------------------------------------------------------
// go_to_goal_steering_assert.svh
// Assertion macros for the go-to-goal steering block. In synthesis the
// macros expand to nothing.
// ----------------------------------------------------------------------------
`ifndef GO_TO_GOAL_STEERING_ASSERT_SVH
`define GO_TO_GOAL_STEERING_ASSERT_SVH

`ifndef SYNTHESIS

// Same-cycle implication, checked on every clock edge outside reset.
`define GTG_ASSERT_IMP(lbl, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error("%m: implication check failed");

// Next-cycle implication, checked on every clock edge outside reset.
`define GTG_ASSERT_NXT(lbl, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error("%m: next-cycle check failed");

`else

`define GTG_ASSERT_IMP(lbl, ante, cons)
`define GTG_ASSERT_NXT(lbl, ante, cons)

`endif

`endif

@@ hw/rtl/gtg_pkg.sv @@
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// gtg_pkg
// Shared types, fixed-point constants, register indices and datapath
// operation codes of the go-to-goal steering block.
// ----------------------------------------------------------------------------
package gtg_pkg;

	// Width of an iteration index carried with each datapath command.
	localparam int STEP_W = 5;
	// Root bits from the square-root unit and quotient bits from the divider.
	localparam int SQRT_ITERS = 17;
	localparam int DIV_ITERS  = 17;

	// Angle constants in Q3.12 and Q.16 radians.
	localparam logic signed [15:0] PI_Q12      = 16'sd12868;
	localparam logic signed [15:0] HALF_PI_Q12 = 16'sd6434;
	localparam logic signed [15:0] TWO_PI_Q12  = 16'sd25736;
	localparam logic signed [19:0] PI_Q16      = 20'sd205887;
	localparam logic signed [19:0] HALF_PI_Q16 = 20'sd102944;
	localparam logic signed [19:0] CORDIC_START = 20'sd39797;

	// Configuration register indices.
	localparam int CFG_IDX_W = 3;
	localparam logic [CFG_IDX_W-1:0] REG_LINEAR_GAIN  = 3'd0;
	localparam logic [CFG_IDX_W-1:0] REG_SPEED_LIMIT  = 3'd1;
	localparam logic [CFG_IDX_W-1:0] REG_ANGULAR_GAIN = 3'd2;
	localparam logic [CFG_IDX_W-1:0] REG_ARRIVE_TOL   = 3'd3;
	localparam logic [CFG_IDX_W-1:0] REG_ACTIVE       = 3'd4;

	// Datapath operations issued by the controller.
	typedef logic [4:0] op_t;
	localparam op_t OP_NONE        = 5'd0;
	localparam op_t OP_CAPTURE     = 5'd1;
	localparam op_t OP_SQ1         = 5'd2;
	localparam op_t OP_SQ2         = 5'd3;
	localparam op_t OP_SQRT_STEP   = 5'd4;
	localparam op_t OP_CHECK       = 5'd5;
	localparam op_t OP_CORDIC_STEP = 5'd6;
	localparam op_t OP_MUL1        = 5'd7;
	localparam op_t OP_MUL2        = 5'd8;
	localparam op_t OP_DIV_INIT    = 5'd9;
	localparam op_t OP_DIV_STEP    = 5'd10;
	localparam op_t OP_DIV_END     = 5'd11;
	localparam op_t OP_RSQ         = 5'd12;
	localparam op_t OP_VEC_INIT    = 5'd13;
	localparam op_t OP_OUT1        = 5'd14;
	localparam op_t OP_OUT2        = 5'd15;
	localparam op_t OP_WRITE       = 5'd16;

	typedef struct packed {
		op_t               op;
		logic [STEP_W-1:0] step;
	} cmd_t;

	typedef struct packed {
		logic eligible;
		logic arrive;
		logic dzero;
		logic out_busy;
	} sts_t;

	// Arctangent of 2^-i in Q.16 radians.
	function automatic logic [16:0] atan_q16(input logic [STEP_W-1:0] i);
		logic [16:0] v;
		unique case (i)
			5'd0:  v = 17'd51472;
			5'd1:  v = 17'd30386;
			5'd2:  v = 17'd16055;
			5'd3:  v = 17'd8150;
			5'd4:  v = 17'd4091;
			5'd5:  v = 17'd2047;
			5'd6:  v = 17'd1024;
			5'd7:  v = 17'd512;
			5'd8:  v = 17'd256;
			5'd9:  v = 17'd128;
			5'd10: v = 17'd64;
			5'd11: v = 17'd32;
			5'd12: v = 17'd16;
			5'd13: v = 17'd8;
			5'd14: v = 17'd4;
			5'd15: v = 17'd2;
			5'd16: v = 17'd1;
			default: v = 17'd0;
		endcase
		return v;
	endfunction

endpackage
`default_nettype wire

@@ hw/rtl/gtg_ctrl.sv @@
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// gtg_ctrl
// Sequencer of the steering block: walks one item through the distance root,
// then as the item needs the heading rotation, division, arcsine and output.
// ----------------------------------------------------------------------------
module gtg_ctrl import gtg_pkg::*; #(
	parameter int CORDIC_STEPS = 16
) (
	input  wire logic clk,
	input  wire logic arst_n,
	input  wire logic in_valid,
	output logic      in_ready,
	input  wire sts_t sts,
	output cmd_t      cmd
);

	localparam logic [4:0] S_IDLE   = 5'd0;
	localparam logic [4:0] S_SQ1    = 5'd1;
	localparam logic [4:0] S_SQ2    = 5'd2;
	localparam logic [4:0] S_SQRTD  = 5'd3;
	localparam logic [4:0] S_CHECK  = 5'd4;
	localparam logic [4:0] S_ROT    = 5'd5;
	localparam logic [4:0] S_MUL1   = 5'd6;
	localparam logic [4:0] S_MUL2   = 5'd7;
	localparam logic [4:0] S_DIVI   = 5'd8;
	localparam logic [4:0] S_DIVS   = 5'd9;
	localparam logic [4:0] S_DIVE   = 5'd10;
	localparam logic [4:0] S_RSQ    = 5'd11;
	localparam logic [4:0] S_SQRTA  = 5'd12;
	localparam logic [4:0] S_VECI   = 5'd13;
	localparam logic [4:0] S_VEC    = 5'd14;
	localparam logic [4:0] S_OUT1   = 5'd15;
	localparam logic [4:0] S_OUT2   = 5'd16;
	localparam logic [4:0] S_WRITE  = 5'd17;

	localparam logic [STEP_W-1:0] SQRT_LAST = STEP_W'(SQRT_ITERS - 1);
	localparam logic [STEP_W-1:0] DIV_LAST  = STEP_W'(DIV_ITERS - 1);
	localparam logic [STEP_W-1:0] ROT_LAST  = STEP_W'(CORDIC_STEPS - 1);

	logic [4:0]        state_q, state_d;
	logic [STEP_W-1:0] cnt_q, cnt_d;

	// Next state, iteration count and the command for this cycle.
	always_comb begin
		state_d  = state_q;
		cnt_d    = cnt_q;
		in_ready = 1'b0;
		cmd.op   = OP_NONE;
		cmd.step = cnt_q;
		unique case (state_q)
			S_IDLE: begin
				in_ready = 1'b1;
				if (in_valid) begin
					cmd.op  = OP_CAPTURE;
					state_d = S_SQ1;
				end
			end
			S_SQ1: begin
				cmd.op  = OP_SQ1;
				state_d = S_SQ2;
			end
			S_SQ2: begin
				cmd.op  = OP_SQ2;
				state_d = S_SQRTD;
			end
			S_SQRTD: begin
				cmd.op = OP_SQRT_STEP;
				if (cnt_q == SQRT_LAST) begin
					cnt_d   = '0;
					state_d = S_CHECK;
				end else begin
					cnt_d = cnt_q + 1'b1;
				end
			end
			S_CHECK: begin
				cmd.op = OP_CHECK;
				priority if (!sts.eligible || sts.arrive) begin
					state_d = S_WRITE;
				end else if (sts.dzero) begin
					state_d = S_OUT1;
				end else begin
					state_d = S_ROT;
				end
			end
			S_ROT: begin
				cmd.op = OP_CORDIC_STEP;
				if (cnt_q == ROT_LAST) begin
					cnt_d   = '0;
					state_d = S_MUL1;
				end else begin
					cnt_d = cnt_q + 1'b1;
				end
			end
			S_MUL1: begin
				cmd.op  = OP_MUL1;
				state_d = S_MUL2;
			end
			S_MUL2: begin
				cmd.op  = OP_MUL2;
				state_d = S_DIVI;
			end
			S_DIVI: begin
				cmd.op  = OP_DIV_INIT;
				state_d = S_DIVS;
			end
			S_DIVS: begin
				cmd.op = OP_DIV_STEP;
				if (cnt_q == DIV_LAST) begin
					cnt_d   = '0;
					state_d = S_DIVE;
				end else begin
					cnt_d = cnt_q + 1'b1;
				end
			end
			S_DIVE: begin
				cmd.op  = OP_DIV_END;
				state_d = S_RSQ;
			end
			S_RSQ: begin
				cmd.op  = OP_RSQ;
				state_d = S_SQRTA;
			end
			S_SQRTA: begin
				cmd.op = OP_SQRT_STEP;
				if (cnt_q == SQRT_LAST) begin
					cnt_d   = '0;
					state_d = S_VECI;
				end else begin
					cnt_d = cnt_q + 1'b1;
				end
			end
			S_VECI: begin
				cmd.op  = OP_VEC_INIT;
				state_d = S_VEC;
			end
			S_VEC: begin
				cmd.op = OP_CORDIC_STEP;
				if (cnt_q == ROT_LAST) begin
					cnt_d   = '0;
					state_d = S_OUT1;
				end else begin
					cnt_d = cnt_q + 1'b1;
				end
			end
			S_OUT1: begin
				cmd.op  = OP_OUT1;
				state_d = S_OUT2;
			end
			S_OUT2: begin
				cmd.op  = OP_OUT2;
				state_d = S_WRITE;
			end
			S_WRITE: begin
				if (!sts.out_busy) begin
					cmd.op  = OP_WRITE;
					state_d = S_IDLE;
				end
			end
			default: begin
				cnt_d   = '0;
				state_d = S_IDLE;
			end
		endcase
	end

	// State and iteration counter.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
			cnt_q   <= '0;
		end else begin
			state_q <= state_d;
			cnt_q   <= cnt_d;
		end
	end

endmodule
`default_nettype wire

@@ hw/rtl/gtg_dpath.sv @@
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// gtg_dpath
// Datapath of the steering block: configuration registers, batch
// bookkeeping, a shared square-root unit, a shared CORDIC unit, a
// restoring divider and the output register.
// ----------------------------------------------------------------------------
module gtg_dpath import gtg_pkg::*; #(
	parameter int MAX_AGENTS = 16
) (
	input  wire logic                 clk,
	input  wire logic                 arst_n,
	input  wire cmd_t                 cmd,
	output sts_t                      sts,
	input  wire logic                 cfg_write_en,
	input  wire logic [CFG_IDX_W-1:0] cfg_index,
	input  wire logic [14:0]          cfg_data,
	input  wire logic                 start_batch,
	input  wire logic [3:0]           agent,
	input  wire logic signed [15:0]   pos_x,
	input  wire logic signed [15:0]   pos_y,
	input  wire logic signed [15:0]   heading,
	input  wire logic signed [15:0]   goal_x,
	input  wire logic signed [15:0]   goal_y,
	output logic                      out_valid,
	input  wire logic                 out_ready,
	output logic [3:0]                agent_out,
	output logic                      command_valid,
	output logic signed [15:0]        linear_speed,
	output logic signed [15:0]        angular_speed,
	output logic                      reached,
	output logic                      all_done
);

	localparam int LEFT_W = $clog2(MAX_AGENTS + 1);
	localparam int BS_W   = (LEFT_W > 5) ? LEFT_W : 5;

	// Configuration and batch state.
	logic [14:0]           linear_gain_q, speed_limit_q, angular_gain_q, arrive_tol_q;
	logic [4:0]            active_q;
	logic [MAX_AGENTS-1:0] flags_q;
	logic [LEFT_W-1:0]     left_q;
	logic                  elig_q, arrive_q, out_valid_q;

	// Item registers.
	logic [3:0]         agent_q;
	logic signed [15:0] px_q, py_q, gx_q, gy_q, h_q;
	logic signed [16:0] dx_q, dy_q;
	logic [33:0]        sq_q, rad_q;
	logic [20:0]        rem_q;
	logic [16:0]        root_q, d_q;
	logic signed [19:0] x_q, y_q, z_q;
	logic               neg_q, vec_q, rev_q;
	logic signed [36:0] p1_q;
	logic signed [37:0] num_q;
	logic [37:0]        dvrem_q;
	logic [32:0]        dv_q;
	logic [16:0]        qt_q;
	logic               sat_q, nneg_q;
	logic signed [17:0] r_q;
	logic [31:0]        lin_prod_q;
	logic signed [36:0] ang_prod_q;
	logic signed [15:0] lin_q, ang_q;

	// Output register.
	logic [3:0]         agent_out_q;
	logic               command_valid_q, reached_q, all_done_q;
	logic signed [15:0] linear_speed_q, angular_speed_q;

	// Batch size and eligibility of the offered item.
	logic [BS_W-1:0]    bsize, agent_ext;
	logic               flag_sel, eligible_c;
	logic signed [15:0] hw;
	logic signed [16:0] dx_c, dy_c;

	always_comb begin
		bsize     = (BS_W'(active_q) < BS_W'(MAX_AGENTS)) ? BS_W'(active_q)
		                                                  : BS_W'(MAX_AGENTS);
		agent_ext = BS_W'(agent);
		flag_sel  = 1'b0;
		for (int i = 0; i < MAX_AGENTS; i++) begin
			if (agent_ext == BS_W'(i)) flag_sel = flags_q[i];
		end
		eligible_c = (agent_ext < bsize) && (start_batch || !flag_sel);
		hw = heading;
		if (heading > PI_Q12) begin
			hw = heading - TWO_PI_Q12;
		end else if (heading < -PI_Q12) begin
			hw = heading + TWO_PI_Q12;
		end
		dx_c = 17'(goal_x) - 17'(pos_x);
		dy_c = 17'(goal_y) - 17'(pos_y);
	end

	// Squares of the offsets.
	logic signed [33:0] dxx, dyy;
	assign dxx = dx_q * dx_q;
	assign dyy = dy_q * dy_q;

	// One root bit per step.
	logic [20:0] rem_sh, trial;
	assign rem_sh = {rem_q[18:0], rad_q[33:32]};
	assign trial  = {2'b00, root_q, 2'b01};

	// Heading in Q.16 folded into the CORDIC range.
	logic signed [19:0] hq, z_fold;
	logic               fold_neg;
	always_comb begin
		hq       = $signed({h_q, 4'b0000});
		z_fold   = hq;
		fold_neg = 1'b0;
		if (hq > HALF_PI_Q16) begin
			z_fold   = hq - PI_Q16;
			fold_neg = 1'b1;
		end else if (hq < -HALF_PI_Q16) begin
			z_fold   = hq + PI_Q16;
			fold_neg = 1'b1;
		end
	end

	// CORDIC micro-rotation, rotation or vectoring mode.
	logic signed [19:0] xs, ys, at;
	logic               up;
	assign xs = y_q >>> cmd.step;
	assign ys = x_q >>> cmd.step;
	assign at = $signed({3'b000, atan_q16(cmd.step)});
	assign up = vec_q ? y_q[19] : ~z_q[19];

	// Cross product of the heading vector with the goal offset.
	logic signed [19:0] cval, sval;
	logic signed [36:0] cp, sp;
	logic signed [37:0] num_c;
	assign cval  = neg_q ? -x_q : x_q;
	assign sval  = neg_q ? -y_q : y_q;
	assign cp    = cval * dy_q;
	assign sp    = sval * dx_q;
	assign num_c = {p1_q[36], p1_q} - {sp[36], sp};

	// Divider operands.
	logic [37:0] num_mag;
	logic [16:0] qmag;
	assign num_mag = num_q[37] ? $unsigned(-num_q) : $unsigned(num_q);
	assign qmag    = (sat_q || qt_q > 17'd65536) ? 17'd65536 : qt_q;

	// Radicand of the arcsine cosine term.
	logic signed [35:0] rsq;
	assign rsq = r_q * r_q;

	// Direction choice.
	logic rev;
	always_comb begin
		priority if (px_q > gx_q) begin
			rev = (h_q > -HALF_PI_Q12) && (h_q < HALF_PI_Q12);
		end else if (px_q < gx_q) begin
			rev = (h_q > HALF_PI_Q12) || (h_q < -HALF_PI_Q12);
		end else if (py_q >= gy_q) begin
			rev = !h_q[15];
		end else begin
			rev = h_q[15];
		end
	end

	// Gain products and final rounding.
	logic [31:0]        lin_p;
	logic signed [36:0] ang_p;
	logic [32:0]        lin_sum;
	logic [22:0]        lin_r;
	logic [14:0]        lin_lim;
	logic signed [15:0] lin_mag;
	logic signed [37:0] ang_sum;
	logic signed [21:0] ang_sh;
	logic signed [15:0] ang_sat;
	always_comb begin
		lin_p   = linear_gain_q * d_q;
		ang_p   = $signed({1'b0, angular_gain_q}) * z_q;
		lin_sum = {1'b0, lin_prod_q} + 33'd512;
		lin_r   = lin_sum[32:10];
		lin_lim = (lin_r > {8'b0, speed_limit_q}) ? speed_limit_q : lin_r[14:0];
		lin_mag = $signed({1'b0, lin_lim});
		ang_sum = {ang_prod_q[36], ang_prod_q} + 38'sd32768;
		ang_sh  = ang_sum[37:16];
		if (ang_sh > 22'sd32767) begin
			ang_sat = 16'sh7FFF;
		end else if (ang_sh < -22'sd32768) begin
			ang_sat = 16'sh8000;
		end else begin
			ang_sat = ang_sh[15:0];
		end
	end

	// Status towards the controller.
	always_comb begin
		sts.eligible = elig_q;
		sts.arrive   = root_q < {2'b00, arrive_tol_q};
		sts.dzero    = (root_q == '0);
		sts.out_busy = out_valid_q && !out_ready;
	end

	// Control state: configuration, batch bookkeeping and output valid.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			linear_gain_q  <= 15'd5120;
			speed_limit_q  <= 15'd5120;
			angular_gain_q <= 15'd6144;
			arrive_tol_q   <= 15'd10;
			active_q       <= 5'd1;
			flags_q        <= '0;
			left_q         <= '0;
			elig_q         <= 1'b0;
			arrive_q       <= 1'b0;
			out_valid_q    <= 1'b0;
		end else begin
			if (cfg_write_en) begin
				unique case (cfg_index)
					REG_LINEAR_GAIN:  linear_gain_q  <= cfg_data;
					REG_SPEED_LIMIT:  speed_limit_q  <= cfg_data;
					REG_ANGULAR_GAIN: angular_gain_q <= cfg_data;
					REG_ARRIVE_TOL:   arrive_tol_q   <= cfg_data;
					REG_ACTIVE:       active_q       <= cfg_data[4:0];
					default: ;
				endcase
			end
			if (cmd.op == OP_CAPTURE) begin
				elig_q <= eligible_c;
				if (start_batch) begin
					flags_q <= '0;
					left_q  <= LEFT_W'(bsize);
				end
			end
			if (cmd.op == OP_CHECK) begin
				arrive_q <= sts.arrive;
				if (elig_q && sts.arrive) begin
					for (int i = 0; i < MAX_AGENTS; i++) begin
						if (BS_W'(agent_q) == BS_W'(i)) flags_q[i] <= 1'b1;
					end
					if (left_q != '0) left_q <= left_q - 1'b1;
				end
			end
			if (cmd.op == OP_WRITE) begin
				out_valid_q <= 1'b1;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	// Arithmetic registers, one operation per command.
	always_ff @(posedge clk) begin
		unique case (cmd.op)
			OP_CAPTURE: begin
				agent_q <= agent;
				px_q    <= pos_x;
				py_q    <= pos_y;
				gx_q    <= goal_x;
				gy_q    <= goal_y;
				h_q     <= hw;
				dx_q    <= dx_c;
				dy_q    <= dy_c;
			end
			OP_SQ1: begin
				sq_q <= $unsigned(dxx);
			end
			OP_SQ2: begin
				rad_q  <= sq_q + $unsigned(dyy);
				rem_q  <= '0;
				root_q <= '0;
			end
			OP_SQRT_STEP: begin
				rad_q <= {rad_q[31:0], 2'b00};
				if (rem_sh >= trial) begin
					rem_q  <= rem_sh - trial;
					root_q <= {root_q[15:0], 1'b1};
				end else begin
					rem_q  <= rem_sh;
					root_q <= {root_q[15:0], 1'b0};
				end
			end
			OP_CHECK: begin
				d_q   <= root_q;
				x_q   <= CORDIC_START;
				y_q   <= '0;
				z_q   <= sts.dzero ? 20'sd0 : z_fold;
				neg_q <= fold_neg;
				vec_q <= 1'b0;
			end
			OP_CORDIC_STEP: begin
				if (up) begin
					x_q <= x_q - xs;
					y_q <= y_q + ys;
					z_q <= z_q - at;
				end else begin
					x_q <= x_q + xs;
					y_q <= y_q - ys;
					z_q <= z_q + at;
				end
			end
			OP_MUL1: begin
				p1_q <= cp;
			end
			OP_MUL2: begin
				num_q <= num_c;
			end
			OP_DIV_INIT: begin
				nneg_q  <= num_q[37];
				dvrem_q <= num_mag;
				dv_q    <= {d_q, 16'b0};
				qt_q    <= '0;
				sat_q   <= num_mag >= {4'b0, d_q, 17'b0};
			end
			OP_DIV_STEP: begin
				dv_q <= {1'b0, dv_q[32:1]};
				if (dvrem_q >= {5'b0, dv_q}) begin
					dvrem_q <= dvrem_q - {5'b0, dv_q};
					qt_q    <= {qt_q[15:0], 1'b1};
				end else begin
					qt_q <= {qt_q[15:0], 1'b0};
				end
			end
			OP_DIV_END: begin
				r_q <= nneg_q ? -$signed({1'b0, qmag}) : $signed({1'b0, qmag});
			end
			OP_RSQ: begin
				rad_q  <= 34'h1_0000_0000 - $unsigned(rsq[33:0]);
				rem_q  <= '0;
				root_q <= '0;
			end
			OP_VEC_INIT: begin
				x_q   <= $signed({3'b000, root_q});
				y_q   <= 20'(r_q);
				z_q   <= '0;
				vec_q <= 1'b1;
			end
			OP_OUT1: begin
				rev_q      <= rev;
				lin_prod_q <= lin_p;
				ang_prod_q <= rev ? -ang_p : ang_p;
			end
			OP_OUT2: begin
				lin_q <= rev_q ? -lin_mag : lin_mag;
				ang_q <= ang_sat;
			end
			OP_WRITE: begin
				agent_out_q     <= agent_q;
				command_valid_q <= elig_q;
				reached_q       <= elig_q && arrive_q;
				linear_speed_q  <= (elig_q && !arrive_q) ? lin_q : 16'sd0;
				angular_speed_q <= (elig_q && !arrive_q) ? ang_q : 16'sd0;
				all_done_q      <= (left_q == '0);
			end
			default: ;
		endcase
	end

	assign out_valid     = out_valid_q;
	assign agent_out     = agent_out_q;
	assign command_valid = command_valid_q;
	assign linear_speed  = linear_speed_q;
	assign angular_speed = angular_speed_q;
	assign reached       = reached_q;
	assign all_done      = all_done_q;

endmodule
`default_nettype wire

@@ hw/rtl/go_to_goal_steering.sv @@
`timescale 1ns / 1ps
`default_nettype none
// Go-to-goal steering for a batch of agents.
// An item on the input channel (in_valid/in_ready) carries one agent's pose
// and goal; each accepted item yields exactly one result on the output
// channel (out_valid/out_ready). Configuration writes go through
// cfg_write_en, cfg_index and cfg_data; the user must make them only while
// the block is idle, since the block itself does not enforce this. Items
// are handled one at a time. A moving command runs through two 17-step
// square roots, a 17-step divider and two CORDIC passes on shared units.
// Stops and skipped agents pass only the distance root before the write,
// and a zero distance under a zero tolerance passes the root and the output
// stage. in_ready rises together with out_valid, so the next item can be
// taken in the cycle in which the result is first offered.
// Reset clears all reached flags, loads the register defaults and sets the
// remaining count to zero, so results report all_done until a batch starts.
// When the receiver stalls, the finished result stays in the output
// register and the next item is held before its result is written.
// ----------------------------------------------------------------------------
// go_to_goal_steering
// Top level: controller and datapath of the go-to-goal steering block.
// ----------------------------------------------------------------------------
`include "go_to_goal_steering_assert.svh"
module go_to_goal_steering import gtg_pkg::*; #(
	parameter int MAX_AGENTS   = 16,
	parameter int CORDIC_STEPS = 16
) (
	input  wire logic                 clk,
	input  wire logic                 arst_n,
	input  wire logic                 cfg_write_en,
	input  wire logic [CFG_IDX_W-1:0] cfg_index,
	input  wire logic [14:0]          cfg_data,
	input  wire logic                 in_valid,
	output logic                      in_ready,
	input  wire logic                 start_batch,
	input  wire logic [3:0]           agent,
	input  wire logic signed [15:0]   pos_x,
	input  wire logic signed [15:0]   pos_y,
	input  wire logic signed [15:0]   heading,
	input  wire logic signed [15:0]   goal_x,
	input  wire logic signed [15:0]   goal_y,
	output logic                      out_valid,
	input  wire logic                 out_ready,
	output logic [3:0]                agent_out,
	output logic                      command_valid,
	output logic signed [15:0]        linear_speed,
	output logic signed [15:0]        angular_speed,
	output logic                      reached,
	output logic                      all_done
);

	cmd_t cmd;
	sts_t sts;

	// Sequencer.
	gtg_ctrl #(
		.CORDIC_STEPS(CORDIC_STEPS)
	) u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (in_valid),
		.in_ready (in_ready),
		.sts      (sts),
		.cmd      (cmd)
	);

	// Arithmetic and state.
	gtg_dpath #(
		.MAX_AGENTS(MAX_AGENTS)
	) u_dpath (
		.clk           (clk),
		.arst_n        (arst_n),
		.cmd           (cmd),
		.sts           (sts),
		.cfg_write_en  (cfg_write_en),
		.cfg_index     (cfg_index),
		.cfg_data      (cfg_data),
		.start_batch   (start_batch),
		.agent         (agent),
		.pos_x         (pos_x),
		.pos_y         (pos_y),
		.heading       (heading),
		.goal_x        (goal_x),
		.goal_y        (goal_y),
		.out_valid     (out_valid),
		.out_ready     (out_ready),
		.agent_out     (agent_out),
		.command_valid (command_valid),
		.linear_speed  (linear_speed),
		.angular_speed (angular_speed),
		.reached       (reached),
		.all_done      (all_done)
	);

	// One item at a time: a transfer is never followed directly by another.
	`GTG_ASSERT_NXT(a_one_item, in_valid && in_ready, !in_ready)
	// A stop is always a command.
	`GTG_ASSERT_IMP(a_reached_cmd, out_valid && reached, command_valid)
	// Stops and skipped agents carry zero speeds.
	`GTG_ASSERT_IMP(a_zero_speed, out_valid && (reached || !command_valid), ~|{linear_speed, angular_speed})

endmodule
`default_nettype wire

@@ test/go_to_goal_steering_tb.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// go_to_goal_steering_tb
// Self-checking testbench for the go-to-goal steering block. A short table
// of directed poses and register writes is followed by random batches under
// several register settings. Each accepted pose is run through a local model
// of the controller and every result transfer is compared field by field.
// ----------------------------------------------------------------------------
module go_to_goal_steering_tb;
	import gtg_pkg::*;

	localparam longint CYCLE_LIMIT = 1000000;
	localparam int AGENTS = 16;
	localparam int STEPS = 16;
	localparam int RANDOM_PHASES = 8;
	localparam int PHASE_ITEMS = 225;
	localparam longint ANG_PI = 12868;
	localparam longint ANG_HALF_PI = 6434;
	localparam longint ANG_PI_Q16 = 205887;
	localparam longint ANG_HALF_PI_Q16 = 102944;
	localparam longint ROT_GAIN_START = 39797;

	typedef enum logic {ROW_POSE, ROW_REG} row_kind_t;

	typedef struct {
		logic              sb;
		logic [3:0]        ag;
		logic signed [15:0] px, py, hd, gx, gy;
	} pose_t;

	typedef struct {
		logic [3:0]        ag;
		logic              valid;
		logic signed [15:0] lin, ang;
		logic              rch, done;
	} steer_cmd_t;

	typedef struct {
		row_kind_t          kind;
		logic [CFG_IDX_W-1:0] idx;
		logic [14:0]        val;
		pose_t              pose;
		bit                 typed;
		steer_cmd_t         cmd;
	} row_t;

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic cfg_write_en = 1'b0;
	logic [CFG_IDX_W-1:0] cfg_index = '0;
	logic [14:0] cfg_data = '0;
	logic in_valid = 1'b0;
	logic in_ready;
	logic start_batch = 1'b0;
	logic [3:0] agent = '0;
	logic signed [15:0] pos_x = '0, pos_y = '0, heading = '0, goal_x = '0, goal_y = '0;
	logic out_valid;
	logic out_ready = 1'b0;
	logic [3:0] agent_out;
	logic command_valid;
	logic signed [15:0] linear_speed, angular_speed;
	logic reached, all_done;

	// Local copy of the controller state and registers.
	bit [AGENTS-1:0] arrived_flags = '0;
	int unsigned agents_remaining = 0;
	longint lin_gain = 5120, lin_limit = 5120, ang_gain = 6144, arrive_tol = 10;
	int unsigned batch_cfg = 1;

	steer_cmd_t cmd_q[$];
	logic typed_now = 1'b0;
	steer_cmd_t typed_cmd;
	int errors = 0;
	longint cycles = 0;
	bit no_idle = 1'b0;
	int stall_left = 0;
	row_t rows[$];

	localparam longint ATAN_TAB[0:23] = '{51472, 30386, 16055, 8150, 4091, 2047, 1024, 512,
		256, 128, 64, 32, 16, 8, 4, 2, 1, 0, 0, 0, 0, 0, 0, 0};

	go_to_goal_steering uut (
		.clk(clk), .arst_n(arst_n),
		.cfg_write_en(cfg_write_en), .cfg_index(cfg_index), .cfg_data(cfg_data),
		.in_valid(in_valid), .in_ready(in_ready),
		.start_batch(start_batch), .agent(agent),
		.pos_x(pos_x), .pos_y(pos_y), .heading(heading), .goal_x(goal_x), .goal_y(goal_y),
		.out_valid(out_valid), .out_ready(out_ready),
		.agent_out(agent_out), .command_valid(command_valid),
		.linear_speed(linear_speed), .angular_speed(angular_speed),
		.reached(reached), .all_done(all_done)
	);

	// Clock generation.
	always #5 clk = ~clk;

	// Cycle counter and watchdog.
	always @(posedge clk) begin
		cycles++;
		if (cycles > CYCLE_LIMIT) begin
			$display("go_to_goal_steering: mismatch");
			$finish;
		end
	end

	// Integer square root, rounded down.
	function automatic longint root_floor(input longint unsigned v);
		longint unsigned res, bitv;
		res = 0;
		bitv = 64'd1 << 62;
		while (bitv > v) bitv >>= 2;
		while (bitv != 0) begin
			if (v >= res + bitv) begin
				v -= res + bitv;
				res = (res >> 1) + bitv;
			end else begin
				res >>= 1;
			end
			bitv >>= 2;
		end
		return longint'(res);
	endfunction

	function automatic longint round_half_up(input longint v, input int s);
		return (v + (longint'(1) << (s - 1))) >>> s;
	endfunction

	// Rotation-mode CORDIC giving cosine and sine of a Q.16 angle.
	function automatic void rotate_unit(input longint ang, output longint c, output longint s);
		longint x, y, z, xs, ys;
		bit neg;
		x = ROT_GAIN_START;
		y = 0;
		z = ang;
		neg = 1'b0;
		if (z > ANG_HALF_PI_Q16) begin
			z -= ANG_PI_Q16;
			neg = 1'b1;
		end else if (z < -ANG_HALF_PI_Q16) begin
			z += ANG_PI_Q16;
			neg = 1'b1;
		end
		for (int i = 0; i < STEPS; i++) begin
			xs = y >>> i;
			ys = x >>> i;
			if (z >= 0) begin
				x -= xs; y += ys; z -= ATAN_TAB[i];
			end else begin
				x += xs; y -= ys; z += ATAN_TAB[i];
			end
		end
		c = neg ? -x : x;
		s = neg ? -y : y;
	endfunction

	// Vectoring-mode CORDIC giving the arcsine of a Q.16 ratio.
	function automatic longint bearing_asin(input longint r);
		longint x, y, z, xs, ys;
		x = root_floor(longint'(64'd1 << 32) - r * r);
		y = r;
		z = 0;
		for (int i = 0; i < STEPS; i++) begin
			xs = y >>> i;
			ys = x >>> i;
			if (y >= 0) begin
				x += xs; y -= ys; z += ATAN_TAB[i];
			end else begin
				x -= xs; y += ys; z -= ATAN_TAB[i];
			end
		end
		return z;
	endfunction

	function automatic int unsigned batch_size();
		return (batch_cfg < AGENTS) ? batch_cfg : AGENTS;
	endfunction

	// Works out the steering command for one pose and advances the state.
	function automatic steer_cmd_t steer_predict(input pose_t p);
		steer_cmd_t o;
		longint dx, dy, d, h, c, s, r, e, lin, ang, sgn, px, py, gx, gy;
		bit rev;
		if (p.sb) begin
			arrived_flags = '0;
			agents_remaining = batch_size();
		end
		o.ag = p.ag;
		o.valid = 1'b0;
		o.lin = '0;
		o.ang = '0;
		o.rch = 1'b0;
		px = p.px; py = p.py; gx = p.gx; gy = p.gy; h = p.hd;
		if (p.ag < batch_size() && !arrived_flags[p.ag]) begin
			dx = gx - px;
			dy = gy - py;
			d = root_floor(longint'(dx * dx + dy * dy));
			o.valid = 1'b1;
			if (h > ANG_PI) h -= 2 * ANG_PI;
			if (h < -ANG_PI) h += 2 * ANG_PI;
			if (d < arrive_tol) begin
				o.rch = 1'b1;
				arrived_flags[p.ag] = 1'b1;
				if (agents_remaining > 0) agents_remaining--;
			end else begin
				e = 0;
				if (d > 0) begin
					rotate_unit(h * 16, c, s);
					r = (c * dy - s * dx) / d;
					if (r > 65536) r = 65536;
					if (r < -65536) r = -65536;
					e = bearing_asin(r);
				end
				if (px > gx) rev = (h > -ANG_HALF_PI && h < ANG_HALF_PI);
				else if (px < gx) rev = (h > ANG_HALF_PI || h < -ANG_HALF_PI);
				else if (py >= gy) rev = (h >= 0);
				else rev = (h < 0);
				sgn = rev ? -1 : 1;
				lin = round_half_up(lin_gain * d, 10);
				if (lin > lin_limit) lin = lin_limit;
				lin *= sgn;
				ang = round_half_up(sgn * ang_gain * e, 16);
				if (ang > 32767) ang = 32767;
				if (ang < -32768) ang = -32768;
				o.lin = lin[15:0];
				o.ang = ang[15:0];
			end
		end
		o.done = (agents_remaining == 0);
		return o;
	endfunction

	task automatic report(input string what, input longint got, input longint want);
		$display("%0t: %s got %0d, expected %0d", $realtime, what, got, want);
		errors++;
	endtask

	// Scoreboard: registers, accepted poses and result transfers.
	always @(posedge clk) begin : monitor
		steer_cmd_t e;
		pose_t p;
		if (arst_n) begin
			if (cfg_write_en) begin
				case (cfg_index)
					REG_LINEAR_GAIN:  lin_gain = cfg_data;
					REG_SPEED_LIMIT:  lin_limit = cfg_data;
					REG_ANGULAR_GAIN: ang_gain = cfg_data;
					REG_ARRIVE_TOL:   arrive_tol = cfg_data;
					REG_ACTIVE:       batch_cfg = cfg_data[4:0];
					default: ;
				endcase
			end
			if (in_valid && in_ready) begin
				p.sb = start_batch; p.ag = agent;
				p.px = pos_x; p.py = pos_y; p.hd = heading; p.gx = goal_x; p.gy = goal_y;
				e = steer_predict(p);
				if (typed_now) e = typed_cmd;
				cmd_q.push_back(e);
			end
			if (out_valid && out_ready) begin
				if (cmd_q.size() == 0) begin
					report("unexpected result transfer, agent_out", agent_out, -1);
				end else begin
					e = cmd_q.pop_front();
					if (agent_out !== e.ag) report("agent_out", agent_out, e.ag);
					if (command_valid !== e.valid) report("command_valid", command_valid, e.valid);
					if (linear_speed !== e.lin) report("linear_speed", linear_speed, e.lin);
					if (angular_speed !== e.ang) report("angular_speed", angular_speed, e.ang);
					if (reached !== e.rch) report("reached", reached, e.rch);
					if (all_done !== e.done) report("all_done", all_done, e.done);
				end
			end
		end
	end

	// Receiver back-pressure: mostly ready, with short and occasional long stalls.
	always @(posedge clk) begin
		if (stall_left > 0) begin
			stall_left--;
			out_ready <= 1'b0;
		end else begin
			out_ready <= 1'b1;
			if (!no_idle && $urandom_range(0, 9) == 0)
				stall_left = ($urandom_range(0, 9) == 0) ? $urandom_range(10, 40)
					: $urandom_range(1, 3);
		end
	end

	function automatic int gap_len();
		int r;
		if (no_idle) return 0;
		r = $urandom_range(0, 99);
		if (r < 60) return 0;
		if (r < 92) return $urandom_range(1, 3);
		return $urandom_range(10, 40);
	endfunction

	task automatic send_pose(input pose_t p, input bit typed, input steer_cmd_t c);
		int g;
		in_valid <= 1'b1;
		start_batch <= p.sb; agent <= p.ag;
		pos_x <= p.px; pos_y <= p.py; heading <= p.hd; goal_x <= p.gx; goal_y <= p.gy;
		typed_now <= typed;
		typed_cmd <= c;
		do @(posedge clk); while (!in_ready);
		g = gap_len();
		if (g > 0) begin
			in_valid <= 1'b0;
			repeat (g) @(posedge clk);
		end
	endtask

	// Holds the sender until every outstanding result has been transferred.
	task automatic wait_idle();
		in_valid <= 1'b0;
		@(posedge clk);
		while (cmd_q.size() != 0) @(posedge clk);
	endtask

	task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [14:0] val);
		cfg_write_en <= 1'b1;
		cfg_index <= idx;
		cfg_data <= val;
		@(posedge clk);
		cfg_write_en <= 1'b0;
		@(posedge clk);
	endtask

	function automatic void add_pose(input logic sb, input logic [3:0] ag,
			input logic signed [15:0] px, py, hd, gx, gy);
		row_t r;
		r.kind = ROW_POSE; r.idx = '0; r.val = '0; r.typed = 1'b0; r.cmd = '{default: '0};
		r.pose = '{sb, ag, px, py, hd, gx, gy};
		rows.push_back(r);
	endfunction

	function automatic void add_typed(input logic sb, input logic [3:0] ag,
			input logic v, input logic rch, input logic done);
		add_pose(sb, ag, 16'sd0, 16'sd0, 16'sd0, 16'sd0, 16'sd0);
		rows[$].typed = 1'b1;
		rows[$].cmd = '{ag, v, 16'sd0, 16'sd0, rch, done};
	endfunction

	function automatic void add_reg(input logic [CFG_IDX_W-1:0] idx, input logic [14:0] val);
		row_t r;
		r.kind = ROW_REG; r.idx = idx; r.val = val; r.typed = 1'b0; r.cmd = '{default: '0};
		r.pose = '{default: '0};
		rows.push_back(r);
	endfunction

	function automatic logic signed [15:0] pick_heading();
		case ($urandom_range(0, 11))
			0: return 16'sd12868;
			1: return -16'sd12868;
			2: return 16'sd6434;
			3: return -16'sd6434;
			4: return 16'sd0;
			5: return 16'sh7fff;
			6: return 16'sh8000;
			default: return $urandom;
		endcase
	endfunction

	// Mostly well-formed batch traffic: in-batch agents near or far from goal.
	function automatic pose_t rand_pose();
		pose_t p;
		int t, o1, o2;
		p.sb = ($urandom_range(0, 39) == 0);
		p.ag = ($urandom_range(0, 99) < 85) ? $urandom_range(0, batch_size() - 1) : $urandom;
		p.hd = pick_heading();
		p.gx = $urandom;
		p.gy = $urandom;
		t = (arrive_tol > 2000) ? 2000 : int'(arrive_tol);
		o1 = $urandom_range(0, 2 * t + 2) - (t + 1);
		o2 = $urandom_range(0, 2 * t + 2) - (t + 1);
		case ($urandom_range(0, 9))
			0, 1, 2, 3: begin
				p.px = $urandom; p.py = $urandom;
			end
			4, 5, 6: begin
				p.px = p.gx + o1; p.py = p.gy + o2;
			end
			7: begin
				p.px = p.gx; p.py = $urandom;
			end
			8: begin
				p.px = p.gx; p.py = p.gy;
			end
			default: begin
				p.px = p.gx + $urandom_range(0, 128) - 64;
				p.py = p.gy + $urandom_range(0, 128) - 64;
			end
		endcase
		return p;
	endfunction

	initial begin : stimulus
		row_t r;
		pose_t p;
		steer_cmd_t none;
		logic [14:0] v;
		none = '{default: '0};

		// Directed table: reset state, arrival, skipped agents, extremes, direction rules.
		add_typed(1'b0, 4'd0, 1'b1, 1'b1, 1'b1);
		add_typed(1'b0, 4'd0, 1'b0, 1'b0, 1'b1);
		add_typed(1'b1, 4'd0, 1'b1, 1'b1, 1'b1);
		add_typed(1'b1, 4'd2, 1'b0, 1'b0, 1'b0);
		add_pose(1'b0, 4'd0, 16'sh8000, 16'sh8000, 16'sh7fff, 16'sh7fff, 16'sh7fff);
		add_pose(1'b0, 4'd0, 16'sh7fff, 16'sh7fff, 16'sh8000, 16'sh8000, 16'sh8000);
		add_pose(1'b0, 4'd0, 16'sd500, 16'sd0, 16'sd12868, 16'sd0, 16'sd300);
		add_pose(1'b0, 4'd0, -16'sd500, 16'sd0, -16'sd12868, 16'sd0, -16'sd300);
		add_pose(1'b0, 4'd0, 16'sd500, 16'sd0, 16'sd6434, 16'sd0, 16'sd300);
		add_pose(1'b0, 4'd0, -16'sd500, 16'sd0, -16'sd6434, 16'sd0, -16'sd300);
		add_pose(1'b0, 4'd0, 16'sd100, 16'sd900, 16'sd0, 16'sd100, 16'sd0);
		add_pose(1'b0, 4'd0, 16'sd100, 16'sd900, -16'sd1, 16'sd100, 16'sd0);
		add_pose(1'b0, 4'd0, 16'sd100, -16'sd900, -16'sd1, 16'sd100, 16'sd0);
		add_pose(1'b0, 4'd0, 16'sd100, -16'sd900, 16'sd1, 16'sd100, 16'sd0);
		add_reg(REG_ARRIVE_TOL, 15'd0);
		add_pose(1'b0, 4'd0, 16'sd77, -16'sd77, 16'sd3000, 16'sd77, -16'sd77);
		add_reg(REG_ACTIVE, 15'd31);
		add_pose(1'b1, 4'd15, 16'sd1000, 16'sd2000, 16'sd4000, -16'sd3000, 16'sd5000);
		add_reg(REG_SPEED_LIMIT, 15'h7fff);
		add_reg(REG_LINEAR_GAIN, 15'h7fff);
		add_reg(REG_ANGULAR_GAIN, 15'h7fff);
		add_pose(1'b0, 4'd3, 16'sh8000, 16'sh7fff, 16'sd9000, 16'sh7fff, 16'sh8000);

		repeat (8) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		foreach (rows[i]) begin
			r = rows[i];
			if (r.kind == ROW_REG) begin
				wait_idle();
				write_reg(r.idx, r.val);
			end else begin
				send_pose(r.pose, r.typed, r.cmd);
			end
		end

		// Random phases, each under its own register setting.
		for (int ph = 0; ph < RANDOM_PHASES; ph++) begin
			wait_idle();
			no_idle = (ph == 3);
			case (ph)
				0: begin
					write_reg(REG_LINEAR_GAIN, 15'h7fff);
					write_reg(REG_SPEED_LIMIT, 15'h7fff);
					write_reg(REG_ANGULAR_GAIN, 15'h7fff);
					write_reg(REG_ARRIVE_TOL, 15'h7fff);
					write_reg(REG_ACTIVE, 15'd16);
				end
				1: begin
					write_reg(REG_LINEAR_GAIN, 15'd0);
					write_reg(REG_SPEED_LIMIT, 15'd0);
					write_reg(REG_ANGULAR_GAIN, 15'd0);
					write_reg(REG_ARRIVE_TOL, 15'd0);
					write_reg(REG_ACTIVE, 15'd1);
				end
				default: begin
					write_reg(REG_LINEAR_GAIN, $urandom_range(0, 32767));
					write_reg(REG_SPEED_LIMIT, $urandom_range(0, 32767));
					write_reg(REG_ANGULAR_GAIN, $urandom_range(0, 32767));
					write_reg(REG_ARRIVE_TOL, $urandom_range(0, 3000));
					v = $urandom;
					v[4:0] = (ph == 2) ? 5'd31 : 5'($urandom_range(1, 16));
					write_reg(REG_ACTIVE, v);
				end
			endcase
			for (int n = 0; n < PHASE_ITEMS; n++) begin
				p = rand_pose();
				send_pose(p, 1'b0, none);
			end
		end

		wait_idle();
		repeat (200) @(posedge clk);
		if (errors == 0)
			$display("go_to_goal_steering: match");
		else
			$display("go_to_goal_steering: mismatch");
		$finish;
	end

endmodule
